FILE: src/arpem_pkg.sv
`timescale 1ns / 1ps
package arpem_pkg;
  localparam int SampleBits = 16;
  localparam int CountBits  = 32;
  localparam int SumBits    = 62;
  localparam int DbBits     = 15;
  localparam int FracBits   = 20;
  localparam logic [31:0] DbScale = 32'd1616142483;

  localparam logic [1:0] REQ_ADD    = 2'd0;
  localparam logic [1:0] REQ_REPORT = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_SQRT,
    ST_LOGP_NORM,
    ST_LOGP_SQ,
    ST_LOGR_NORM,
    ST_LOGR_SQ,
    ST_SCALE,
    ST_OUT
  } state_t;

  function automatic logic [15:0] threshold(input int k);
    threshold = 16'(((k << (SampleBits - 1)) + 19) / 20);
  endfunction
endpackage

FILE: src/arpem_log2.sv
`timescale 1ns / 1ps
module arpem_log2 (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] x,
  output logic        done,
  output logic [24:0] result
);
  logic [4:0]  n;
  logic [4:0]  step;
  logic        busy;
  logic [31:0] m;
  logic [19:0] frac;
  logic [63:0] sq;
  logic [31:0] msq;
  logic [4:0]  lz;

  always_comb begin
    lz = 5'd0;
    for (int i = 0; i < 16; i++) begin
      if (x[i]) begin
        lz = 5'(i);
      end
    end
  end

  assign sq  = {32'd0, m} * {32'd0, m};
  assign msq = sq[61:30];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      n    <= lz;
      m    <= 32'(x) << (5'd30 - lz);
      frac <= '0;
      step <= '0;
    end else if (busy) begin
      frac <= {frac[18:0], msq[31]};
      m    <= msq[31] ? {1'b0, msq[31:1]} : msq;
      step <= step + 5'd1;
      busy <= (step != 5'(arpem_pkg::FracBits - 1));
      done <= (step == 5'(arpem_pkg::FracBits - 1));
    end else begin
      done <= 1'b0;
    end
  end

  assign result = {n, frac};
endmodule

FILE: src/audio_rms_peak_energy_meter.sv
`timescale 1ns / 1ps
// Level meter over signed Q1.15 samples. After an add or a clear beat,
// in_stall is raised in the cycle after the beat. A report beat runs a
// 62-bit restoring divider, a bit-serial square root and one log2 unit
// reused for peak and RMS (a set-up state before each), then one scaling
// multiply; the log2 steps and the multiply are skipped when the range is
// zero (zero RMS, or peak not above RMS). The result is held in an output
// register until taken; new beats are accepted meanwhile, and a further
// report waits in its last cycle only while the previous result is still
// held.
module audio_rms_peak_energy_meter (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic signed [15:0] sample,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] rms_level,
  output logic [15:0] peak_level,
  output logic [14:0] range_db,
  output logic [3:0]  energy_rating,
  output logic [2:0]  label_code,
  output logic [31:0] samples_counted
);
  arpem_pkg::state_t state, state_next;
  logic [61:0] square_sum;
  logic [31:0] sample_total;
  logic [15:0] peak_magnitude;
  logic [61:0] quo;
  logic [62:0] rem;
  logic [6:0]  cnt;
  logic [31:0] sq_res;
  logic [61:0] sq_val;
  logic [15:0] rms;
  logic [24:0] lp;
  logic        log_start, log_done;
  logic [15:0] log_x;
  logic [24:0] log_res;
  logic [57:0] prod;
  logic        accept, add_busy;
  logic [15:0] mag;
  logic [31:0] mag_sq;
  logic [14:0] db_val;
  logic [3:0]  rating;
  logic        out_load;
  logic        no_range;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != arpem_pkg::ST_IDLE) || add_busy;
  assign mag      = sample[15] ? 16'(-sample) : 16'(sample);
  assign mag_sq   = 32'(mag) * 32'(mag);
  assign out_load = (state == arpem_pkg::ST_OUT) && !(out_valid && out_stall);
  assign no_range = (sq_res[15:0] == 16'd0) || (peak_magnitude <= sq_res[15:0]);

  arpem_log2 u_log (.clk, .rst, .start(log_start), .x(log_x), .done(log_done),
    .result(log_res));

  always_comb begin
    state_next = state;
    case (state)
      arpem_pkg::ST_IDLE:
        if (accept && req_type == arpem_pkg::REQ_REPORT) state_next = arpem_pkg::ST_DIV;
      arpem_pkg::ST_DIV:  if (cnt == 7'd61) state_next = arpem_pkg::ST_SQRT;
      arpem_pkg::ST_SQRT: if (cnt == 7'd30) state_next = arpem_pkg::ST_LOGP_NORM;
      arpem_pkg::ST_LOGP_NORM:
        state_next = no_range ? arpem_pkg::ST_OUT : arpem_pkg::ST_LOGP_SQ;
      arpem_pkg::ST_LOGP_SQ:   if (log_done) state_next = arpem_pkg::ST_LOGR_NORM;
      arpem_pkg::ST_LOGR_NORM: state_next = arpem_pkg::ST_LOGR_SQ;
      arpem_pkg::ST_LOGR_SQ:   if (log_done) state_next = arpem_pkg::ST_SCALE;
      arpem_pkg::ST_SCALE:     state_next = arpem_pkg::ST_OUT;
      arpem_pkg::ST_OUT:       if (out_load) state_next = arpem_pkg::ST_IDLE;
      default:                 state_next = arpem_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    log_start = 1'b0;
    log_x     = peak_magnitude;
    case (state)
      arpem_pkg::ST_LOGP_NORM: log_start = !no_range;
      arpem_pkg::ST_LOGR_NORM: begin
        log_start = 1'b1;
        log_x     = rms;
      end
      default: log_start = 1'b0;
    endcase
  end

  assign prod  = {33'd0, log_res > lp ? 25'd0 : lp - log_res} * {26'd0, arpem_pkg::DbScale};

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= arpem_pkg::ST_IDLE;
      square_sum     <= '0;
      sample_total   <= '0;
      peak_magnitude <= '0;
      add_busy       <= 1'b0;
      cnt            <= '0;
    end else begin
      state    <= state_next;
      add_busy <= accept && (req_type inside {arpem_pkg::REQ_ADD, arpem_pkg::REQ_CLEAR});
      if (accept && req_type == arpem_pkg::REQ_ADD) begin
        if (mag > peak_magnitude) peak_magnitude <= mag;
        if (sample_total != '1) begin
          square_sum   <= square_sum + 62'(mag_sq);
          sample_total <= sample_total + 32'd1;
        end
      end
      if (accept && req_type == arpem_pkg::REQ_CLEAR) begin
        square_sum     <= '0;
        sample_total   <= '0;
        peak_magnitude <= '0;
      end
      case (state)
        arpem_pkg::ST_IDLE: begin
          cnt <= '0;
          rem <= '0;
          quo <= square_sum;
        end
        arpem_pkg::ST_DIV: begin
          if (sample_total == 0) begin
            quo <= '0;
          end else if ({rem[61:0], quo[61]} >= {31'd0, sample_total}) begin
            rem <= {rem[61:0], quo[61]} - {31'd0, sample_total};
            quo <= {quo[60:0], 1'b1};
          end else begin
            rem <= {rem[61:0], quo[61]};
            quo <= {quo[60:0], 1'b0};
          end
          cnt <= (cnt == 7'd61) ? 7'd0 : cnt + 7'd1;
          if (cnt == 7'd61) begin
            sq_res <= '0;
            sq_val <= '0;
          end
        end
        arpem_pkg::ST_SQRT: begin
          // one result bit per cycle, top bit first
          if ({sq_val[59:0], quo[61:60]} >= {30'd0, sq_res[29:0], 2'b01}) begin
            sq_val <= {sq_val[59:0], quo[61:60]} - {30'd0, sq_res[29:0], 2'b01};
            sq_res <= {sq_res[30:0], 1'b1};
          end else begin
            sq_val <= {sq_val[59:0], quo[61:60]};
            sq_res <= {sq_res[30:0], 1'b0};
          end
          quo <= {quo[59:0], 2'b00};
          cnt <= cnt + 7'd1;
        end
        arpem_pkg::ST_LOGP_NORM: begin
          rms    <= sq_res[15:0];
          db_val <= '0;
        end
        arpem_pkg::ST_LOGR_NORM: lp <= log_res;
        arpem_pkg::ST_SCALE: begin
          if ((prod + 58'(64'd1 << 39)) >> 40 > 58'd32767) db_val <= 15'h7FFF;
          else db_val <= 15'(((prod + 58'(64'd1 << 39)) >> 40));
        end
        default: cnt <= cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rms_level       <= rms;
      peak_level      <= peak_magnitude;
      range_db        <= db_val;
      energy_rating   <= rating;
      label_code      <= 3'((rating - 4'd1) >> 1);
      samples_counted <= sample_total;
    end
  end

  always_comb begin
    logic [3:0] r;
    r = 4'd1;
    for (int k = 2; k <= 10; k++) begin
      if (arpem_pkg::threshold(k) <= rms) r = r + 4'd1;
    end
    rating = r;
  end

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid) else $error("result dropped");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    state != arpem_pkg::ST_IDLE |-> in_stall) else $error("accept while busy");
  a_rms: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> energy_rating >= 4'd1 && energy_rating <= 4'd10)
    else $error("bad rating");
`endif
endmodule
